@@ hw/rtl/rsf_pkg.sv @@
// Shared types, constants and helpers for the rectangle subtract fragmenter.
`default_nettype none

package rsf_pkg;

  // Coordinate width of every position and size field
  localparam int unsigned COORD_BITS     = 16;
  localparam int unsigned TAG_BITS       = 8;
  localparam int unsigned CFG_INDEX_BITS = 2;
  // Edge sums need two more bits than a coordinate
  localparam int unsigned WIDE_BITS      = COORD_BITS + 2;
  // Band height difference needs one more bit again
  localparam int unsigned SPAN_BITS      = COORD_BITS + 3;
  localparam int unsigned SIDE_CNT       = 5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] dim_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic signed [SPAN_BITS-1:0]  span_t;
  typedef logic        [TAG_BITS-1:0]   tag_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CLIP_X      = 2'd0,
    CFG_CLIP_Y      = 2'd1,
    CFG_CLIP_WIDTH  = 2'd2,
    CFG_CLIP_HEIGHT = 2'd3
  } cfg_reg_e;

  // Fragment side codes
  typedef enum logic [2:0] {
    SIDE_TOP    = 3'd0,
    SIDE_BOTTOM = 3'd1,
    SIDE_LEFT   = 3'd2,
    SIDE_RIGHT  = 3'd3,
    SIDE_WHOLE  = 3'd4
  } side_e;

  typedef struct packed {
    coord_t clip_x;
    coord_t clip_y;
    dim_t   clip_width;
    dim_t   clip_height;
  } clip_t;

  typedef struct packed {
    coord_t src_x;
    coord_t src_y;
    dim_t   src_width;
    dim_t   src_height;
    coord_t src_rel_x;
    coord_t src_rel_y;
    tag_t   sheet_tag;
  } src_t;

  typedef struct packed {
    coord_t frag_x;
    coord_t frag_y;
    dim_t   frag_width;
    dim_t   frag_height;
    coord_t frag_rel_x;
    coord_t frag_rel_y;
    tag_t   frag_tag;
    side_e  frag_side;
    logic   last;
  } frag_t;

  // Edges of source and clip after the first stage
  typedef struct packed {
    wide_t  sx;
    wide_t  sy;
    dim_t   sw;
    dim_t   sh;
    wide_t  sr;
    wide_t  sb;
    wide_t  cx;
    wide_t  cy;
    wide_t  cr;
    wide_t  cb;
    coord_t offx;
    coord_t offy;
    tag_t   tag;
  } bounds_t;

  // Fragment plan: one mask bit per side, geometry for all of them
  typedef struct packed {
    logic [SIDE_CNT-1:0] mask;
    coord_t sx;
    coord_t sy;
    dim_t   sw;
    dim_t   sh;
    coord_t offx;
    coord_t offy;
    tag_t   tag;
    dim_t   top_h;
    coord_t bot_y;
    dim_t   bot_h;
    dim_t   left_w;
    coord_t right_x;
    dim_t   right_w;
    coord_t band_top;
    dim_t   band_h;
  } plan_t;

  function automatic wide_t sext(coord_t v);
    return wide_t'({{(WIDE_BITS - COORD_BITS){v[COORD_BITS-1]}}, v});
  endfunction

  function automatic wide_t zext(dim_t v);
    return wide_t'({{(WIDE_BITS - COORD_BITS){1'b0}}, v});
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rsf_bounds.sv @@
// First pipeline stage: edge sums and absolute-to-relative offsets.
`default_nettype none

module rsf_bounds (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  rsf_pkg::src_t        src_i,
  input  rsf_pkg::clip_t       clip_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output rsf_pkg::bounds_t     bounds_o
);
  import rsf_pkg::*;

  logic    valid_q;
  bounds_t bounds_d, bounds_q;

  assign ready_o = !valid_q || ready_i;

  // Widen and sum the edges
  always_comb begin
    bounds_d.sx   = sext(src_i.src_x);
    bounds_d.sy   = sext(src_i.src_y);
    bounds_d.sw   = src_i.src_width;
    bounds_d.sh   = src_i.src_height;
    bounds_d.sr   = sext(src_i.src_x) + zext(src_i.src_width);
    bounds_d.sb   = sext(src_i.src_y) + zext(src_i.src_height);
    bounds_d.cx   = sext(clip_i.clip_x);
    bounds_d.cy   = sext(clip_i.clip_y);
    bounds_d.cr   = sext(clip_i.clip_x) + zext(clip_i.clip_width);
    bounds_d.cb   = sext(clip_i.clip_y) + zext(clip_i.clip_height);
    bounds_d.offx = src_i.src_x - src_i.src_rel_x;
    bounds_d.offy = src_i.src_y - src_i.src_rel_y;
    bounds_d.tag  = src_i.sheet_tag;
  end

  // Advance the valid bit when the next stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      bounds_q <= bounds_d;
    end
  end

  assign valid_o  = valid_q;
  assign bounds_o = bounds_q;

endmodule

`default_nettype wire

@@ hw/rtl/rsf_classify.sv @@
// Second and third pipeline stages: overlap tests, fragment sizes and the side mask.
`default_nettype none

module rsf_classify (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  rsf_pkg::bounds_t     bounds_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output rsf_pkg::plan_t       plan_o
);
  import rsf_pkg::*;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    dim_t   sw;
    dim_t   sh;
    coord_t offx;
    coord_t offy;
    tag_t   tag;
    logic   touch;
    logic   covered;
    logic   top_ok;
    logic   bot_ok;
    logic   left_ok;
    logic   right_ok;
    dim_t   top_h;
    coord_t bot_y;
    dim_t   bot_h;
    dim_t   left_w;
    coord_t right_x;
    dim_t   right_w;
    coord_t band_top;
    wide_t  band_bot;
  } class_t;

  logic   cls_valid_q, plan_valid_q;
  logic   cls_ready, plan_ready;
  class_t cls_d, cls_q;
  plan_t  plan_d, plan_q;

  assign plan_ready = !plan_valid_q || ready_i;
  assign cls_ready  = !cls_valid_q || plan_ready;
  assign ready_o    = cls_ready;

  // Compare edges and form the per-side sizes
  always_comb begin
    wide_t sx, sy, sr, sb, cx, cy, cr, cb;
    wide_t top_h, bot_h, left_w, right_w, band_top;
    sx = bounds_i.sx;
    sy = bounds_i.sy;
    sr = bounds_i.sr;
    sb = bounds_i.sb;
    cx = bounds_i.cx;
    cy = bounds_i.cy;
    cr = bounds_i.cr;
    cb = bounds_i.cb;
    top_h    = cy - sy;
    bot_h    = sb - cb;
    left_w   = cx - sx;
    right_w  = sr - cr;
    band_top = (cy > sy) ? cy : sy;

    cls_d.sx       = sx[COORD_BITS-1:0];
    cls_d.sy       = sy[COORD_BITS-1:0];
    cls_d.sw       = bounds_i.sw;
    cls_d.sh       = bounds_i.sh;
    cls_d.offx     = bounds_i.offx;
    cls_d.offy     = bounds_i.offy;
    cls_d.tag      = bounds_i.tag;
    cls_d.touch    = (sr >= cx) && (cr >= sx) && (sb >= cy) && (cb >= sy);
    cls_d.covered  = (sx >= cx) && (sy >= cy) && (sr <= cr) && (sb <= cb);
    cls_d.top_ok   = (cy > sy) && (bounds_i.sw != '0);
    cls_d.bot_ok   = (cb < sb) && (bounds_i.sw != '0);
    cls_d.left_ok  = (cx > sx);
    cls_d.right_ok = (cr < sr);
    cls_d.top_h    = top_h[COORD_BITS-1:0];
    cls_d.bot_y    = cb[COORD_BITS-1:0];
    cls_d.bot_h    = bot_h[COORD_BITS-1:0];
    cls_d.left_w   = left_w[COORD_BITS-1:0];
    cls_d.right_x  = cr[COORD_BITS-1:0];
    cls_d.right_w  = right_w[COORD_BITS-1:0];
    cls_d.band_top = band_top[COORD_BITS-1:0];
    cls_d.band_bot = (cb < sb) ? cb : sb;
  end

  // Band height and the side mask
  always_comb begin
    span_t bot_s, top_s, band_h;
    logic  band_ok;
    bot_s   = span_t'({cls_q.band_bot[WIDE_BITS-1], cls_q.band_bot});
    top_s   = span_t'({{(SPAN_BITS - COORD_BITS){cls_q.band_top[COORD_BITS-1]}},
                       cls_q.band_top});
    band_h  = bot_s - top_s;
    band_ok = (band_h > 0);

    plan_d.sx       = cls_q.sx;
    plan_d.sy       = cls_q.sy;
    plan_d.sw       = cls_q.sw;
    plan_d.sh       = cls_q.sh;
    plan_d.offx     = cls_q.offx;
    plan_d.offy     = cls_q.offy;
    plan_d.tag      = cls_q.tag;
    plan_d.top_h    = cls_q.top_h;
    plan_d.bot_y    = cls_q.bot_y;
    plan_d.bot_h    = cls_q.bot_h;
    plan_d.left_w   = cls_q.left_w;
    plan_d.right_x  = cls_q.right_x;
    plan_d.right_w  = cls_q.right_w;
    plan_d.band_top = cls_q.band_top;
    plan_d.band_h   = band_h[COORD_BITS-1:0];

    // Untouched source passes whole; a covered one yields nothing
    if (!cls_q.touch) begin
      plan_d.mask = SIDE_CNT'(1) << SIDE_WHOLE;
    end else if (cls_q.covered) begin
      plan_d.mask = '0;
    end else begin
      plan_d.mask = '0;
      plan_d.mask[SIDE_TOP]    = cls_q.top_ok;
      plan_d.mask[SIDE_BOTTOM] = cls_q.bot_ok;
      plan_d.mask[SIDE_LEFT]   = cls_q.left_ok && band_ok;
      plan_d.mask[SIDE_RIGHT]  = cls_q.right_ok && band_ok;
    end
  end

  // Advance valid bits stage by stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_valid_q  <= 1'b0;
      plan_valid_q <= 1'b0;
    end else begin
      if (cls_ready) begin
        cls_valid_q <= valid_i;
      end
      if (plan_ready) begin
        plan_valid_q <= cls_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cls_ready) begin
      cls_q <= cls_d;
    end
    if (plan_ready) begin
      plan_q <= plan_d;
    end
  end

  assign valid_o = plan_valid_q;
  assign plan_o  = plan_q;

endmodule

`default_nettype wire

@@ hw/rtl/rsf_emit.sv @@
// Fragment issue stage: walks the side mask and drives the output register.
`default_nettype none

module rsf_emit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  rsf_pkg::plan_t       plan_i,
  output logic                 frag_valid_o,
  input  wire logic            frag_stall_i,
  output rsf_pkg::frag_t       frag_o
);
  import rsf_pkg::*;

  logic [SIDE_CNT-1:0] mask_q, rest;
  plan_t               plan_q;
  logic                busy, out_ready, pop, load;
  logic                out_valid_q;
  frag_t               frag_d, frag_q;

  assign busy      = |mask_q;
  assign out_ready = !out_valid_q || !frag_stall_i;
  assign pop       = busy && out_ready;
  // Clear the lowest pending side
  assign rest      = mask_q & (mask_q - SIDE_CNT'(1));
  assign ready_o   = !busy || (pop && (rest == '0));
  assign load      = valid_i && ready_o;

  // Select the geometry of the lowest pending side
  always_comb begin
    frag_d.frag_tag = plan_q.tag;
    frag_d.last     = (rest == '0);
    if (mask_q[SIDE_TOP]) begin
      frag_d.frag_side   = SIDE_TOP;
      frag_d.frag_x      = plan_q.sx;
      frag_d.frag_y      = plan_q.sy;
      frag_d.frag_width  = plan_q.sw;
      frag_d.frag_height = plan_q.top_h;
    end else if (mask_q[SIDE_BOTTOM]) begin
      frag_d.frag_side   = SIDE_BOTTOM;
      frag_d.frag_x      = plan_q.sx;
      frag_d.frag_y      = plan_q.bot_y;
      frag_d.frag_width  = plan_q.sw;
      frag_d.frag_height = plan_q.bot_h;
    end else if (mask_q[SIDE_LEFT]) begin
      frag_d.frag_side   = SIDE_LEFT;
      frag_d.frag_x      = plan_q.sx;
      frag_d.frag_y      = plan_q.band_top;
      frag_d.frag_width  = plan_q.left_w;
      frag_d.frag_height = plan_q.band_h;
    end else if (mask_q[SIDE_RIGHT]) begin
      frag_d.frag_side   = SIDE_RIGHT;
      frag_d.frag_x      = plan_q.right_x;
      frag_d.frag_y      = plan_q.band_top;
      frag_d.frag_width  = plan_q.right_w;
      frag_d.frag_height = plan_q.band_h;
    end else begin
      frag_d.frag_side   = SIDE_WHOLE;
      frag_d.frag_x      = plan_q.sx;
      frag_d.frag_y      = plan_q.sy;
      frag_d.frag_width  = plan_q.sw;
      frag_d.frag_height = plan_q.sh;
    end
    frag_d.frag_rel_x = frag_d.frag_x - plan_q.offx;
    frag_d.frag_rel_y = frag_d.frag_y - plan_q.offy;
  end

  // Load a new plan or drop the side just issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        mask_q <= plan_i.mask;
      end else if (pop) begin
        mask_q <= rest;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!frag_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      plan_q <= plan_i;
    end
    if (pop) begin
      frag_q <= frag_d;
    end
  end

  assign frag_valid_o = out_valid_q;
  assign frag_o       = frag_q;

endmodule

`default_nettype wire

@@ hw/rtl/rect_subtract_fragmenter_core.sv @@
// Top level of the rectangle subtract fragmenter: clip registers and pipeline.
//
//   channel   direction  handshake                 payload
//   src       in         src_valid_i / src_stall_o  src_i  (rsf_pkg::src_t)
//   frag      out        frag_valid_o / frag_stall_i frag_o (rsf_pkg::frag_t)
//   cfg       in         cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// A source transfer is accepted in any cycle the pipeline has room; its first
// fragment reaches frag_o via the bounds, classify, plan, issue and output
// registers. The issue stage sends one fragment per cycle unless frag_stall_i
// holds its output. Reset clears the clip registers and all valid bits.
// frag_stall_i backs up through every stage; no item is lost or repeated.
`default_nettype none

module rect_subtract_fragmenter_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 src_valid_i,
  output logic                                      src_stall_o,
  input  rsf_pkg::src_t                             src_i,
  output logic                                      frag_valid_o,
  input  wire logic                                 frag_stall_i,
  output rsf_pkg::frag_t                            frag_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rsf_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  wire logic [rsf_pkg::COORD_BITS-1:0]       cfg_wdata_i
);
  import rsf_pkg::*;

  clip_t   clip_q;
  logic    src_ready;
  logic    bnd_valid, bnd_ready;
  bounds_t bnd;
  logic    plan_valid, plan_ready;
  plan_t   plan;

  // Write the clip registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CLIP_X:      clip_q.clip_x      <= cfg_wdata_i;
        CFG_CLIP_Y:      clip_q.clip_y      <= cfg_wdata_i;
        CFG_CLIP_WIDTH:  clip_q.clip_width  <= cfg_wdata_i;
        CFG_CLIP_HEIGHT: clip_q.clip_height <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign src_stall_o = !src_ready;

  rsf_bounds u_bounds (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (src_valid_i),
    .ready_o  (src_ready),
    .src_i    (src_i),
    .clip_i   (clip_q),
    .valid_o  (bnd_valid),
    .ready_i  (bnd_ready),
    .bounds_o (bnd)
  );

  rsf_classify u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (bnd_valid),
    .ready_o  (bnd_ready),
    .bounds_i (bnd),
    .valid_o  (plan_valid),
    .ready_i  (plan_ready),
    .plan_o   (plan)
  );

  rsf_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (plan_valid),
    .ready_o      (plan_ready),
    .plan_i       (plan),
    .frag_valid_o (frag_valid_o),
    .frag_stall_i (frag_stall_i),
    .frag_o       (frag_o)
  );

endmodule

`default_nettype wire
